### hw/rtl/rrht_pkg.sv
// ----------------------------------------------------------------------------
// rrht_pkg
// Shared types and constants for the rectangle region hit table: request codes,
// table geometry, the stored rectangle record, the memory command and the result.
// ----------------------------------------------------------------------------
package rrht_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int COORD_W     = 16;
   localparam int SIZE_W      = 15;
   localparam int VALUE_W     = 32;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;
   localparam logic [1:0] OP_SET    = 2'd3;

   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ENTRIES);

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
   } rect_type;

   typedef struct packed {
      logic [1:0]                op;
      logic [IDX_W-1:0]          index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic [SIZE_W-1:0]         width;
      logic [SIZE_W-1:0]         height;
      logic signed [VALUE_W-1:0] value;
   } request_type;

   typedef struct packed {
      logic [IDX_W-1:0]          rd_addr;
      logic                      rect_we;
      logic                      value_we;
      logic [IDX_W-1:0]          wr_addr;
      rect_type                  wr_rect;
      logic signed [VALUE_W-1:0] wr_value;
   } mem_cmd_type;

   typedef struct packed {
      logic                      hit;
      logic [IDX_W-1:0]          hit_index;
      logic signed [VALUE_W-1:0] value_out;
      logic                      error;
   } result_type;

endpackage

### hw/rtl/rectangle_region_hit_table.sv
// ----------------------------------------------------------------------------
// rectangle_region_hit_table
// Table of up to MAX_ENTRIES rectangles with values: entry write, point lookup
// returning the lowest containing entry, value get and value set.
// ----------------------------------------------------------------------------
// After acceptance, a write, set or error runs through states EXEC and DONE, a
// get through EXEC, SCAN and DONE, and a lookup through EXEC, one SCAN step per
// entry tested (at most the active count) and DONE. One transaction at a time;
// the scan reads one entry per cycle from the entry memory's single read port.
// A new request is taken the cycle after the result enters the output register.
// Synchronous reset clears the valid flags, active count and both channels.
// ----------------------------------------------------------------------------
module rectangle_region_hit_table
   import rrht_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      csr_write_enable,
   input  logic [CNT_W-1:0]          csr_write_data,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic [SIZE_W-1:0]         req_rect_width,
   input  logic [SIZE_W-1:0]         req_rect_height,
   input  logic signed [VALUE_W-1:0] req_value_in,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic [IDX_W-1:0]          rsp_hit_index,
   output logic signed [VALUE_W-1:0] rsp_value_out,
   output logic                      rsp_error
);

   logic [CNT_W-1:0]          active_ff, active_in;
   logic [CNT_W-1:0]          count;
   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                rsp_ff, rsp_in;

   request_type               request;
   logic                      start;
   logic                      busy;
   logic                      done;
   logic                      out_free;
   result_type                result;
   mem_cmd_type               cmd;
   rect_type                  rd_rect;
   logic signed [VALUE_W-1:0] rd_value;
   logic [MAX_ENTRIES-1:0]    entry_valid;

   assign active_in = csr_write_enable ? csr_write_data : active_ff;
   // clamp an oversized active count to the table size
   assign count     = (active_ff > MAX_COUNT) ? MAX_COUNT : active_ff;

   assign request.op      = req_type;
   assign request.index   = req_entry_index;
   assign request.coord_x = req_coord_x;
   assign request.coord_y = req_coord_y;
   assign request.width   = req_rect_width;
   assign request.height  = req_rect_height;
   assign request.value   = req_value_in;

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   rrht_store u_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rd_rect     (rd_rect),
      .rd_value    (rd_value),
      .entry_valid (entry_valid)
   );

   rrht_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .request     (request),
      .count       (count),
      .rd_rect     (rd_rect),
      .rd_value    (rd_value),
      .entry_valid (entry_valid),
      .out_free    (out_free),
      .busy        (busy),
      .done        (done),
      .result      (result),
      .cmd         (cmd)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_hit_index = rsp_ff.hit_index;
   assign rsp_value_out = rsp_ff.value_out;
   assign rsp_error     = rsp_ff.error;

endmodule

### hw/rtl/rrht_store.sv
// ----------------------------------------------------------------------------
// rrht_store
// Entry storage: a rectangle memory and a value memory with registered
// reads, plus the per-entry valid flags.
// ----------------------------------------------------------------------------
module rrht_store
   import rrht_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  mem_cmd_type               cmd,
   output rect_type                  rd_rect,
   output logic signed [VALUE_W-1:0] rd_value,
   output logic [MAX_ENTRIES-1:0]    entry_valid
);

   rect_type                  rect_mem [MAX_ENTRIES];
   logic signed [VALUE_W-1:0] value_mem [MAX_ENTRIES];

   rect_type                  rd_rect_ff;
   logic signed [VALUE_W-1:0] rd_value_ff;
   logic [MAX_ENTRIES-1:0]    valid_ff;
   logic [MAX_ENTRIES-1:0]    valid_in;

   always_ff @(posedge clock) begin
      if (cmd.rect_we) begin
         rect_mem[cmd.wr_addr] <= cmd.wr_rect;
      end
      if (cmd.value_we) begin
         value_mem[cmd.wr_addr] <= cmd.wr_value;
      end
      rd_rect_ff  <= rect_mem[cmd.rd_addr];
      rd_value_ff <= value_mem[cmd.rd_addr];
   end

   // a full entry write marks the entry valid; a value-only set does not
   always_comb begin
      valid_in = valid_ff;
      if (cmd.rect_we) begin
         valid_in[cmd.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_rect     = rd_rect_ff;
   assign rd_value    = rd_value_ff;
   assign entry_valid = valid_ff;

endmodule

### hw/rtl/rrht_engine.sv
// ----------------------------------------------------------------------------
// rrht_engine
// Request sequencer: decodes one transaction, drives the entry memories,
// scans entries one per cycle for a lookup and holds the finished result.
// ----------------------------------------------------------------------------
module rrht_engine
   import rrht_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  request_type               request,
   input  logic [CNT_W-1:0]          count,
   input  rect_type                  rd_rect,
   input  logic signed [VALUE_W-1:0] rd_value,
   input  logic [MAX_ENTRIES-1:0]    entry_valid,
   input  logic                      out_free,
   output logic                      busy,
   output logic                      done,
   output result_type                result,
   output mem_cmd_type               cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic             get_ff, get_in;
   request_type      req_ff, req_in;
   logic [IDX_W-1:0] tag_ff, tag_in;
   result_type       res_ff, res_in;

   logic             in_range;
   logic             last_entry;
   logic [COORD_W:0] dx, dy;
   logic             point_in;

   assign in_range   = {1'b0, req_ff.index} < count;
   assign last_entry = ({1'b0, tag_ff} + 1'b1) == count;

   // point - origin must land in [0, size-1] on both axes
   assign dx = {req_ff.coord_x[COORD_W-1], req_ff.coord_x}
             - {rd_rect.origin_x[COORD_W-1], rd_rect.origin_x};
   assign dy = {req_ff.coord_y[COORD_W-1], req_ff.coord_y}
             - {rd_rect.origin_y[COORD_W-1], rd_rect.origin_y};
   assign point_in = !dx[COORD_W] && (dx[COORD_W-1:0] < {1'b0, rd_rect.width})
                  && !dy[COORD_W] && (dy[COORD_W-1:0] < {1'b0, rd_rect.height});

   always_comb begin
      state_in = state_ff;
      get_in   = get_ff;
      tag_in   = tag_ff;
      res_in   = res_ff;
      req_in   = start ? request : req_ff;

      cmd.rd_addr          = tag_ff + 1'b1;
      cmd.rect_we          = 1'b0;
      cmd.value_we         = 1'b0;
      cmd.wr_addr          = req_ff.index;
      cmd.wr_rect.origin_x = req_ff.coord_x;
      cmd.wr_rect.origin_y = req_ff.coord_y;
      cmd.wr_rect.width    = req_ff.width;
      cmd.wr_rect.height   = req_ff.height;
      cmd.wr_value         = req_ff.value;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in = '0;
            get_in = 1'b0;
            if (req_ff.op == OP_LOOKUP) begin
               if (count == '0) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.rd_addr = '0;
                  tag_in      = '0;
                  state_in    = ST_SCAN;
               end
            end else if (!in_range) begin
               res_in.error = 1'b1;
               state_in     = ST_DONE;
            end else begin
               unique case (req_ff.op)
                  OP_WRITE: begin
                     cmd.rect_we  = 1'b1;
                     cmd.value_we = 1'b1;
                     state_in     = ST_DONE;
                  end
                  OP_SET: begin
                     cmd.value_we = 1'b1;
                     state_in     = ST_DONE;
                  end
                  OP_GET: begin
                     // reuse the scan slot to wait for the registered read data
                     cmd.rd_addr = req_ff.index;
                     get_in      = 1'b1;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (get_ff) begin
               if (entry_valid[req_ff.index]) begin
                  res_in.value_out = rd_value;
               end else begin
                  res_in.error = 1'b1;
               end
               state_in = ST_DONE;
            end else if (entry_valid[tag_ff] && point_in) begin
               res_in.hit       = 1'b1;
               res_in.hit_index = tag_ff;
               state_in         = ST_DONE;
            end else if (last_entry) begin
               state_in = ST_DONE;
            end else begin
               // next entry's read is already issued at tag + 1
               tag_in = tag_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      get_ff <= get_in;
      req_ff <= req_in;
      tag_ff <= tag_in;
      res_ff <= res_in;
   end

   assign busy   = state_ff != ST_IDLE;
   assign done   = state_ff == ST_DONE;
   assign result = res_ff;

endmodule
